>>> hdl/swtg_pkg.sv
// Shared types, constants and codes for the square-wave tone generator.
// No dependencies; other hdl/ files except swtg_result_if.sv use it by scoped names.
package swtg_pkg;

    // Clock and prescaler
    localparam int unsigned CLOCK_HZ    = 16000000;
    localparam int unsigned SLOW_DIVIDE = 64;

    // Field and state widths
    localparam int unsigned FREQ_W  = 16;
    localparam int unsigned DUR_W   = 16;
    localparam int unsigned CMP_W   = 16;
    localparam int unsigned TOG_W   = 24;
    localparam int unsigned PRESC_W = $clog2(SLOW_DIVIDE);
    localparam int unsigned HALF_W  = $clog2(CLOCK_HZ + 1);
    localparam int unsigned PROD_W  = FREQ_W + DUR_W;

    // Shared divider word: holds the clock rate and 2*SLOW_DIVIDE*f
    localparam int unsigned SLOWDIV_W = FREQ_W + $clog2(2 * SLOW_DIVIDE);
    localparam int unsigned DIV_W     = (SLOWDIV_W > HALF_W) ? SLOWDIV_W : HALF_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

    // Toggle count 2*f*d/1000 = (f*d/4)/125, taken by a reciprocal multiply that is
    // exact for every 30-bit value of f*d/4
    localparam int unsigned TOG_QUOT_W = PROD_W - 2;
    localparam int unsigned RECIP_W    = 31;
    localparam int unsigned TOG_RECIP  = 1099511628;   // ceil(2^37 / 125)
    localparam int unsigned TOG_SHIFT  = 37;

    // Arithmetic constants
    localparam int unsigned MS_PER_S = 1000;
    // A half period above this does not fit the 16-bit compare at full rate
    localparam int unsigned CMP_SPAN = 32'h0001_0000;

    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input op codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef logic [FREQ_W-1:0]    freq_t;
    typedef logic [DUR_W-1:0]     dur_t;
    typedef logic [CMP_W-1:0]     cmp_t;
    typedef logic [TOG_W-1:0]     tog_t;
    typedef logic [PRESC_W-1:0]   presc_t;
    typedef logic [HALF_W-1:0]    half_t;
    typedef logic [PROD_W-1:0]    prod_t;
    typedef logic [DIV_W-1:0]     div_word_t;
    typedef logic [DIV_CNT_W-1:0] div_cnt_t;
    typedef logic [QPTR_W-1:0]    qptr_t;
    typedef logic [QCNT_W-1:0]    qcnt_t;
    typedef logic [TOG_QUOT_W+RECIP_W-1:0] tog_prod_t;

    // Classified command kinds
    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_STOP,
        CMD_TONE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        freq_t     frequency;
        dur_t      duration_ms;
    } cmd_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

    // Divider request and response
    typedef struct packed {
        logic      start;
        div_word_t dividend;
        div_word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic      done;
        div_word_t quotient;
    } div_rsp_t;

    // Back-end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HALF,
        BK_SLOW,
        BK_TOG,
        BK_LOAD
    } back_state_t;

endpackage

>>> hdl/swtg_item_if.sv
// Input channel interface: valid/ready handshake with op, frequency, duration_ms.
// Depends on swtg_pkg for field types.
interface swtg_item_if;
    logic           valid;
    logic           ready;
    logic           op;
    swtg_pkg::freq_t frequency;
    swtg_pkg::dur_t  duration_ms;

    modport source (output valid, output op, output frequency, output duration_ms,
                    input ready);
    modport sink   (input valid, input op, input frequency, input duration_ms,
                    output ready);
endinterface

>>> hdl/swtg_result_if.sv
// Result channel interface: valid/ready handshake with pin_level and active.
// No dependencies.
interface swtg_result_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic active;

    modport source (output valid, output pin_level, output active, input ready);
    modport sink   (input valid, input pin_level, input active, output ready);
endinterface

>>> hdl/swtg_front.sv
// Front end: accepts input transactions, classifies them and queues them for the back end.
// Depends on swtg_pkg and swtg_item_if.
module swtg_front (
    input  logic               clk,
    input  logic               rst_n,
    swtg_item_if.sink          item,
    output swtg_pkg::head_t    head,
    input  logic               pop
);

    swtg_pkg::cmd_t  q_reg [swtg_pkg::QUEUE_DEPTH];
    swtg_pkg::qptr_t wr_ptr_reg;
    swtg_pkg::qptr_t wr_ptr_next;
    swtg_pkg::qptr_t rd_ptr_reg;
    swtg_pkg::qptr_t rd_ptr_next;
    swtg_pkg::qcnt_t count_reg;
    swtg_pkg::qcnt_t count_next;
    swtg_pkg::cmd_t  in_cmd;
    logic            push;
    logic            do_pop;

    // Classify the incoming transaction
    always_comb
    begin
        in_cmd.frequency   = item.frequency;
        in_cmd.duration_ms = item.duration_ms;
        if (item.op == swtg_pkg::OP_START)
        begin
            in_cmd.kind = (item.frequency == '0) ? swtg_pkg::CMD_STOP : swtg_pkg::CMD_TONE;
        end
        else
        begin
            in_cmd.kind = swtg_pkg::CMD_TICK;
        end
    end

    assign item.ready = (count_reg != swtg_pkg::qcnt_t'(swtg_pkg::QUEUE_DEPTH));
    assign push       = item.valid && item.ready;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.cmd   = q_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == swtg_pkg::qptr_t'(swtg_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + swtg_pkg::qptr_t'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == swtg_pkg::qptr_t'(swtg_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + swtg_pkg::qptr_t'(1);
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + swtg_pkg::qcnt_t'(1);
            2'b01:   count_next = count_reg - swtg_pkg::qcnt_t'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the queued command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> hdl/swtg_div.sv
// Shared restoring divider, one quotient bit per cycle over the full DIV_W-bit word.
// Depends on swtg_pkg.
module swtg_div (
    input  logic                clk,
    input  logic                rst_n,
    input  swtg_pkg::div_req_t  req,
    output swtg_pkg::div_rsp_t  rsp
);

    swtg_pkg::div_word_t rem_reg;
    swtg_pkg::div_word_t rem_next;
    swtg_pkg::div_word_t quo_reg;
    swtg_pkg::div_word_t quo_next;
    swtg_pkg::div_word_t dvs_reg;
    swtg_pkg::div_word_t dvs_next;
    swtg_pkg::div_cnt_t  cnt_reg;
    swtg_pkg::div_cnt_t  cnt_next;
    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [swtg_pkg::DIV_W:0] trial;
    logic [swtg_pkg::DIV_W:0] diff;
    logic                     fits;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, quo_reg[swtg_pkg::DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    // Load on start, step while busy
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = swtg_pkg::div_cnt_t'(swtg_pkg::DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[swtg_pkg::DIV_W-1:0] : trial[swtg_pkg::DIV_W-1:0];
            quo_next = {quo_reg[swtg_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg - swtg_pkg::div_cnt_t'(1);
            if (cnt_reg == swtg_pkg::div_cnt_t'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> hdl/swtg_back.sv
// Back end: runs the timer on ticks, computes tone settings through the shared
// divider on start commands, and holds the result register.
// Depends on swtg_pkg and swtg_result_if.
module swtg_back (
    input  logic                clk,
    input  logic                rst_n,
    input  swtg_pkg::head_t     head,
    output logic                pop,
    output swtg_pkg::div_req_t  div_req,
    input  swtg_pkg::div_rsp_t  div_rsp,
    swtg_result_if.source       result
);

    swtg_pkg::back_state_t state_reg;
    swtg_pkg::back_state_t state_next;

    // Timer and tone state
    swtg_pkg::presc_t presc_reg;
    swtg_pkg::presc_t presc_next;
    swtg_pkg::cmp_t   timer_reg;
    swtg_pkg::cmp_t   timer_next;
    swtg_pkg::cmp_t   cmp_reg;
    swtg_pkg::cmp_t   cmp_next;
    logic             slow_reg;
    logic             slow_next;
    swtg_pkg::tog_t   tog_reg;
    swtg_pkg::tog_t   tog_next;
    logic             run_reg;
    logic             run_next;
    logic             pin_reg;
    logic             pin_next;

    // Tone setup working registers
    swtg_pkg::freq_t  freq_reg;
    swtg_pkg::freq_t  freq_next;
    swtg_pkg::prod_t  prod_reg;
    swtg_pkg::prod_t  prod_next;
    swtg_pkg::half_t  half_reg;
    swtg_pkg::half_t  half_next;
    swtg_pkg::half_t  slowq_reg;
    swtg_pkg::half_t  slowq_next;
    swtg_pkg::tog_t   togq_reg;
    swtg_pkg::tog_t   togq_next;

    // Result register
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_pin_reg;
    logic             out_pin_next;
    logic             out_act_reg;
    logic             out_act_next;

    // Tick evaluation
    logic             tick_wrap;
    logic             tick_step;
    swtg_pkg::presc_t tick_presc;
    swtg_pkg::cmp_t   tick_timer;
    swtg_pkg::tog_t   tick_tog;
    logic             tick_run;
    logic             tick_pin;

    // Tone load evaluation
    logic             tone_slow;
    swtg_pkg::half_t  half_less;
    swtg_pkg::half_t  slowq_less;
    swtg_pkg::cmp_t   tone_cmp;
    swtg_pkg::tog_prod_t tog_prod;

    logic             slot_free;
    logic             emit;

    assign slot_free = !out_valid_reg || result.ready;

    // Evaluate one tick of the timer and the compare match
    always_comb
    begin
        tick_wrap  = (presc_reg >= swtg_pkg::presc_t'(swtg_pkg::SLOW_DIVIDE - 1));
        tick_presc = tick_wrap ? '0 : presc_reg + swtg_pkg::presc_t'(1);
        tick_step  = !slow_reg || tick_wrap;
        tick_timer = timer_reg;
        tick_tog   = tog_reg;
        tick_run   = run_reg;
        tick_pin   = pin_reg;
        if (tick_step)
        begin
            if (timer_reg == cmp_reg)
            begin
                tick_timer = '0;
                if (run_reg)
                begin
                    if (tog_reg != '0)
                    begin
                        tick_pin = !pin_reg;
                        tick_tog = tog_reg - swtg_pkg::tog_t'(1);
                    end
                    else
                    begin
                        tick_run = 1'b0;
                        tick_pin = 1'b0;
                    end
                end
            end
            else
            begin
                tick_timer = timer_reg + swtg_pkg::cmp_t'(1);
            end
        end
    end

    // Pick the prescale and compare value from the two half-period quotients
    always_comb
    begin
        tone_slow  = (half_reg == '0) || (half_reg > swtg_pkg::half_t'(swtg_pkg::CMP_SPAN));
        half_less  = half_reg - swtg_pkg::half_t'(1);
        slowq_less = slowq_reg - swtg_pkg::half_t'(1);
        tone_cmp   = tone_slow ? slowq_less[swtg_pkg::CMP_W-1:0]
                               : half_less[swtg_pkg::CMP_W-1:0];
    end

    // Divide f*d/4 by 125 through the scaled reciprocal
    always_comb
    begin
        tog_prod = swtg_pkg::tog_prod_t'(prod_reg[swtg_pkg::PROD_W-1:2])
                 * swtg_pkg::tog_prod_t'(swtg_pkg::TOG_RECIP);
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swtg_pkg::BK_IDLE:
            begin
                if (head.valid && slot_free && head.cmd.kind == swtg_pkg::CMD_TONE)
                begin
                    state_next = swtg_pkg::BK_HALF;
                end
            end
            swtg_pkg::BK_HALF:
            begin
                if (div_rsp.done)
                begin
                    state_next = swtg_pkg::BK_SLOW;
                end
            end
            swtg_pkg::BK_SLOW:
            begin
                if (div_rsp.done)
                begin
                    state_next = swtg_pkg::BK_TOG;
                end
            end
            swtg_pkg::BK_TOG:
            begin
                state_next = swtg_pkg::BK_LOAD;
            end
            swtg_pkg::BK_LOAD:
            begin
                if (slot_free)
                begin
                    state_next = swtg_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = swtg_pkg::BK_IDLE;
            end
        endcase
    end

    // Sequencer outputs and datapath updates
    always_comb
    begin
        pop              = 1'b0;
        emit             = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        presc_next       = presc_reg;
        timer_next       = timer_reg;
        cmp_next         = cmp_reg;
        slow_next        = slow_reg;
        tog_next         = tog_reg;
        run_next         = run_reg;
        pin_next         = pin_reg;
        freq_next        = freq_reg;
        prod_next        = prod_reg;
        half_next        = half_reg;
        slowq_next       = slowq_reg;
        togq_next        = togq_reg;
        case (state_reg)
            swtg_pkg::BK_IDLE:
            begin
                if (head.valid && slot_free)
                begin
                    pop = 1'b1;
                    case (head.cmd.kind)
                        swtg_pkg::CMD_TICK:
                        begin
                            emit       = 1'b1;
                            presc_next = tick_presc;
                            timer_next = tick_timer;
                            tog_next   = tick_tog;
                            run_next   = tick_run;
                            pin_next   = tick_pin;
                        end
                        swtg_pkg::CMD_STOP:
                        begin
                            emit     = 1'b1;
                            run_next = 1'b0;
                            pin_next = 1'b0;
                            tog_next = '0;
                        end
                        swtg_pkg::CMD_TONE:
                        begin
                            freq_next        = head.cmd.frequency;
                            prod_next        = swtg_pkg::prod_t'(head.cmd.frequency)
                                             * swtg_pkg::prod_t'(head.cmd.duration_ms);
                            div_req.start    = 1'b1;
                            div_req.dividend = swtg_pkg::div_word_t'(swtg_pkg::CLOCK_HZ);
                            div_req.divisor  = swtg_pkg::div_word_t'({head.cmd.frequency, 1'b0});
                        end
                        default:
                        begin
                            pop = 1'b0;
                        end
                    endcase
                end
            end
            swtg_pkg::BK_HALF:
            begin
                if (div_rsp.done)
                begin
                    half_next        = div_rsp.quotient[swtg_pkg::HALF_W-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = swtg_pkg::div_word_t'(swtg_pkg::CLOCK_HZ);
                    div_req.divisor  = swtg_pkg::div_word_t'(freq_reg)
                                     * swtg_pkg::div_word_t'(2 * swtg_pkg::SLOW_DIVIDE);
                end
            end
            swtg_pkg::BK_SLOW:
            begin
                if (div_rsp.done)
                begin
                    slowq_next = div_rsp.quotient[swtg_pkg::HALF_W-1:0];
                end
            end
            swtg_pkg::BK_TOG:
            begin
                togq_next = tog_prod[swtg_pkg::TOG_SHIFT +: swtg_pkg::TOG_W];
            end
            swtg_pkg::BK_LOAD:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    cmp_next  = tone_cmp;
                    slow_next = tone_slow;
                    tog_next  = togq_reg;
                    run_next  = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Hold the result until taken; load it with the updated pin and run state
    always_comb
    begin
        out_pin_next   = out_pin_reg;
        out_act_next   = out_act_reg;
        out_valid_next = out_valid_reg && !result.ready;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_pin_next   = pin_next;
            out_act_next   = run_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swtg_pkg::BK_IDLE;
            presc_reg     <= '0;
            timer_reg     <= '0;
            cmp_reg       <= '0;
            slow_reg      <= 1'b0;
            tog_reg       <= '0;
            run_reg       <= 1'b0;
            pin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            presc_reg     <= presc_next;
            timer_reg     <= timer_next;
            cmp_reg       <= cmp_next;
            slow_reg      <= slow_next;
            tog_reg       <= tog_next;
            run_reg       <= run_next;
            pin_reg       <= pin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg    <= freq_next;
        prod_reg    <= prod_next;
        half_reg    <= half_next;
        slowq_reg   <= slowq_next;
        togq_reg    <= togq_next;
        out_pin_reg <= out_pin_next;
        out_act_reg <= out_act_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.pin_level = out_pin_reg;
    assign result.active    = out_act_reg;

endmodule

>>> hdl/square_wave_tone_generator.sv
// Square-wave tone generator. Ticks: an accepted tick passes through a 2-entry queue, the timer
// update in the back end and the result register; one tick per cycle sustained while the
// result side takes each result. Start with nonzero frequency: two passes through the shared
// bit-per-cycle divider and one reciprocal multiply, then a load; a stop is done in idle.
// Reset (rst_n, asynchronous, active low) clears timer, prescaler, compare, toggle count,
// pin and run state, empties the queue and drops any pending result.
module square_wave_tone_generator (
    input  logic          clk,
    input  logic          rst_n,
    swtg_item_if.sink     item,
    swtg_result_if.source result
);

    swtg_pkg::head_t    head;
    logic               pop;
    swtg_pkg::div_req_t div_req;
    swtg_pkg::div_rsp_t div_rsp;

    // Accept and classify transactions
    swtg_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .head  (head),
        .pop   (pop)
    );

    // Shared divider for tone setup
    swtg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Execute commands and drive results
    swtg_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .result  (result)
    );

endmodule

>>> test/square_wave_tone_generator_test.sv
// Self-checking testbench for square_wave_tone_generator: directed and random tick/start traffic
// with bursty input, stalled output and a transaction-level tone predictor as scoreboard.
// Depends on hdl/swtg_pkg.sv, hdl/swtg_item_if.sv, hdl/swtg_result_if.sv and the block itself.
module square_wave_tone_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int MIN_MATCHES    = 4;
    localparam int RANDOM_CAP     = 30000;
    localparam int HOLD_AFTER     = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 150;
    localparam int LIMIT_CYCLES   = 2000000;
    // Lowest frequency that still fits the compare at full rate, and the one just below it
    localparam int FAST_EDGE_HZ   = 123;
    localparam int SLOW_EDGE_HZ   = 122;

    typedef struct packed {
        swtg_pkg::presc_t presc;
        swtg_pkg::cmp_t   timer;
        swtg_pkg::cmp_t   compare;
        logic             slow;
        swtg_pkg::tog_t   toggles;
        logic             running;
        logic             pin;
    } tone_state_t;

    typedef struct packed {
        logic            op;
        swtg_pkg::freq_t frequency;
        swtg_pkg::dur_t  duration_ms;
        logic            drain;
    } tone_request_t;

    typedef struct packed {
        logic pin;
        logic active;
    } tone_level_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_SPARSE,
        RX_PATTERN,
        RX_COIN
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    swtg_item_if   item_ch ();
    swtg_result_if result_ch ();

    square_wave_tone_generator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    tone_request_t tone_requests[$];
    tone_level_t   tone_levels_due[$];
    tone_state_t   tone_model;
    tone_state_t   plan_state;
    int            planned_items   = 0;
    int            plan_matches    = 0;
    int            items_accepted  = 0;
    int            mismatches      = 0;
    int            cycles_run      = 0;
    logic          item_taken      = 1'b0;

    // Clock
    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Apply one transaction to a tone state; return 1 when a compare match acted on a tone
    function automatic logic step_tone(inout tone_state_t s, input logic op,
                                       input swtg_pkg::freq_t f, input swtg_pkg::dur_t d);
        logic            wrap;
        logic            advance;
        logic            acted;
        int unsigned     half;
        int unsigned     cmp_w;
        longint unsigned count;
        acted = 1'b0;
        if (op == swtg_pkg::OP_START)
        begin
            if (f == '0)
            begin
                s.running = 1'b0;
                s.pin     = 1'b0;
                s.toggles = '0;
            end
            else
            begin
                half  = swtg_pkg::CLOCK_HZ / 32'(f) / 2;
                cmp_w = half - 1;
                // Too long for the compare at full rate: switch to the slow prescale
                if (half == 0 || cmp_w > 32'hFFFF)
                begin
                    cmp_w  = half / swtg_pkg::SLOW_DIVIDE - 1;
                    s.slow = 1'b1;
                end
                else
                begin
                    s.slow = 1'b0;
                end
                s.compare = cmp_w[swtg_pkg::CMP_W-1:0];
                count     = (64'd2 * 64'(f) * 64'(d)) / 64'(swtg_pkg::MS_PER_S);
                s.toggles = count[swtg_pkg::TOG_W-1:0];
                s.running = 1'b1;
            end
        end
        else
        begin
            wrap    = (s.presc >= swtg_pkg::SLOW_DIVIDE - 1);
            s.presc = wrap ? '0 : s.presc + 1'b1;
            advance = s.slow ? wrap : 1'b1;
            if (advance)
            begin
                if (s.timer == s.compare)
                begin
                    s.timer = '0;
                    if (s.running)
                    begin
                        acted = 1'b1;
                        if (s.toggles != '0)
                        begin
                            s.pin     = ~s.pin;
                            s.toggles = s.toggles - 1'b1;
                        end
                        else
                        begin
                            s.running = 1'b0;
                            s.pin     = 1'b0;
                        end
                    end
                end
                else
                begin
                    s.timer = s.timer + 1'b1;
                end
            end
        end
        return acted;
    endfunction

    // Queue a transaction and advance the planning copy of the tone state
    task automatic plan_item(input logic op, input swtg_pkg::freq_t f,
                             input swtg_pkg::dur_t d, input logic drain);
        tone_request_t req;
        req.op          = op;
        req.frequency   = f;
        req.duration_ms = d;
        req.drain       = drain;
        tone_requests.push_back(req);
        planned_items++;
        if (step_tone(plan_state, op, f, d))
            plan_matches++;
    endtask

    task automatic plan_ticks(input int n);
        repeat (n)
            plan_item(swtg_pkg::OP_TICK, 16'($urandom), 16'($urandom), 1'b0);
    endtask

    // Lower a frequency until its compare sits at or above the planned timer
    function automatic swtg_pkg::freq_t reachable_freq(input swtg_pkg::freq_t first_try);
        tone_state_t     trial;
        swtg_pkg::freq_t f;
        f = first_try;
        for (int tries = 0; tries < 64; tries++)
        begin
            trial = plan_state;
            void'(step_tone(trial, swtg_pkg::OP_START, f, '0));
            if (!trial.slow && trial.compare >= trial.timer)
                break;
            f = (f <= FAST_EDGE_HZ + 16) ? swtg_pkg::freq_t'(FAST_EDGE_HZ) : f - f / 8 - 1'b1;
        end
        return f;
    endfunction

    task automatic report_mismatch(input string field, input logic got, input logic want);
        $display("%0t: %s got %b expected %b", $time, field, got, want);
        mismatches++;
    endtask

    // Sample both channels: check results against the oldest prediction, predict new items
    always @(posedge clk)
    begin : check_levels
        tone_level_t want;
        tone_level_t next_level;
        item_taken = rst_n && item_ch.valid && item_ch.ready;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (tone_levels_due.size() == 0)
            begin
                report_mismatch("result valid", 1'b1, 1'b0);
            end
            else
            begin
                want = tone_levels_due.pop_front();
                if (result_ch.pin_level !== want.pin)
                    report_mismatch("pin_level", result_ch.pin_level, want.pin);
                if (result_ch.active !== want.active)
                    report_mismatch("active", result_ch.active, want.active);
            end
        end
        if (item_taken)
        begin
            void'(step_tone(tone_model, item_ch.op, item_ch.frequency, item_ch.duration_ms));
            next_level.pin    = tone_model.pin;
            next_level.active = tone_model.running;
            tone_levels_due.push_back(next_level);
            items_accepted++;
        end
    end

    // Offer queued transactions in bursts with random gaps; hold an item until it is taken
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk)
    begin : feed_items
        tone_request_t req;
        logic          offer;
        offer = 1'b0;
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
        end
        else if (!(item_ch.valid && !item_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (tone_requests.size() > 0 &&
                     (!tone_requests[0].drain || tone_levels_due.size() == 0))
            begin
                req = tone_requests.pop_front();
                item_ch.op          <= req.op;
                item_ch.frequency   <= req.frequency;
                item_ch.duration_ms <= req.duration_ms;
                offer = 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 300)
                                                             : $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            item_ch.valid <= offer;
        end
    end

    // Stall the result side in stretches of differing patterns, with one long hold-off
    int       hold_left    = 0;
    logic     hold_done    = 1'b0;
    int       stretch_left = 0;
    int       rx_phase     = 0;
    rx_mode_t rx_mode      = RX_OPEN;

    always @(negedge clk)
    begin : stall_results
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else if (!hold_done && items_accepted >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(16, 160);
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
            end
            stretch_left--;
            rx_phase = (rx_phase + 1) % 3;
            case (rx_mode)
                RX_OPEN:    result_ch.ready <= 1'b1;
                RX_SPARSE:  result_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: result_ch.ready <= (rx_phase != 0);
                default:    result_ch.ready <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    // End the run at a generous cycle limit
    always @(posedge clk)
    begin : watchdog
        cycles_run++;
        if (cycles_run >= LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Build the stimulus, release reset, then wait for every result
    initial
    begin : run_test
        tone_state_t     trial;
        swtg_pkg::freq_t f;
        swtg_pkg::dur_t  d;
        int              kind;
        int              random_start;
        logic            drain;

        rst_n               = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.op          = swtg_pkg::OP_TICK;
        item_ch.frequency   = '0;
        item_ch.duration_ms = '0;
        result_ch.ready     = 1'b0;
        tone_model          = '0;
        plan_state          = '0;

        // Idle ticks: the zero compare matches on every step but nothing plays
        plan_ticks(2);
        // Stop while idle, then field extremes and the largest toggle count
        plan_item(swtg_pkg::OP_START, 16'h0000, 16'h0000, 1'b0);
        plan_item(swtg_pkg::OP_START, 16'h0000, 16'hFFFF, 1'b0);
        plan_item(swtg_pkg::OP_START, 16'hFFFF, 16'hFFFF, 1'b0);
        plan_ticks(3);
        // Slowest tone: slow prescale with a truncated compare
        plan_item(swtg_pkg::OP_START, 16'd1, 16'h0000, 1'b0);
        plan_ticks(2);
        plan_item(swtg_pkg::OP_START, 16'd1, 16'hFFFF, 1'b0);
        // Either side of the prescale switch
        plan_item(swtg_pkg::OP_START, 16'(SLOW_EDGE_HZ), 16'd1, 1'b0);
        plan_ticks(1);
        plan_item(swtg_pkg::OP_START, 16'(FAST_EDGE_HZ), 16'd1, 1'b0);
        // Zero duration, then stop a running tone
        plan_item(swtg_pkg::OP_START, 16'hFFFF, 16'h0000, 1'b0);
        plan_ticks(2);
        plan_item(swtg_pkg::OP_START, 16'h0000, 16'h0000, 1'b0);
        plan_ticks(1);
        plan_item(swtg_pkg::OP_START, 16'd40000, 16'd1000, 1'b0);
        plan_item(swtg_pkg::OP_START, 16'h0000, 16'h5A5A, 1'b0);

        // Slow-prescale tone of zero duration, started once everything before it is out
        plan_item(swtg_pkg::OP_START, 16'(SLOW_EDGE_HZ), 16'h0000, 1'b1);
        plan_ticks($urandom_range(5, 30));

        // Random tone sessions, stops and noise
        random_start = planned_items;
        while ((planned_items - random_start < RANDOM_ITEMS || plan_matches < MIN_MATCHES) &&
               planned_items - random_start < RANDOM_CAP)
        begin
            kind  = $urandom_range(0, 99);
            drain = ($urandom_range(0, 29) == 0);
            if (kind < 70)
            begin
                // Occasionally drop the compare below the running timer first
                trial = plan_state;
                void'(step_tone(trial, swtg_pkg::OP_START, 16'hFFFF, '0));
                if (kind < 8 && trial.compare < trial.timer)
                begin
                    plan_item(swtg_pkg::OP_START, 16'hFFFF, 16'($urandom_range(0, 3)), drain);
                    drain = 1'b0;
                    plan_ticks($urandom_range(1, 12));
                end
                f = reachable_freq(16'($urandom_range(40000, 65535)));
                case ($urandom_range(0, 9))
                    0, 1, 2:       d = '0;
                    3, 4, 5, 6, 7: d = 16'($urandom_range(1, 3));
                    default:       d = 16'($urandom);
                endcase
                plan_item(swtg_pkg::OP_START, f, d, drain);
                plan_ticks($urandom_range(40, 360));
            end
            else if (kind < 82)
            begin
                plan_item(swtg_pkg::OP_START, 16'h0000, 16'($urandom), drain);
                plan_ticks($urandom_range(1, 20));
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    plan_item(($urandom_range(0, 1) == 1) ? swtg_pkg::OP_START : swtg_pkg::OP_TICK,
                              16'($urandom), 16'($urandom), drain);
                    drain = 1'b0;
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (tone_requests.size() != 0 || item_ch.valid)
            @(posedge clk);
        while (tone_levels_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/swtg_pkg.sv
hdl/swtg_item_if.sv
hdl/swtg_result_if.sv
hdl/swtg_front.sv
hdl/swtg_div.sv
hdl/swtg_back.sv
hdl/square_wave_tone_generator.sv
test/square_wave_tone_generator_test.sv
